### src/bcib_pkg.sv
// Shared types and constants for the block constraint index builder.
// No dependencies; imported by the top level.
package bcib_pkg;

	localparam int NUM_BLOCKS_DEF   = 64;
	localparam int BUCKET_DEPTH_DEF = 256;

	// field widths fixed by the stream format
	localparam int CID_W    = 12;
	localparam int POS_W    = 6;
	localparam int BLK_W    = 6;
	localparam int RANK_W   = 8;
	localparam int COUNT_W  = 9;
	localparam int CFG_W    = 7;
	localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 7'd64;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANK  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

endpackage

### src/bcib_count_mem.sv
// Per-block entry counters: synchronous memory with a registered read port.
// Valid bits cleared at reset make never-written counters read as zero.
module bcib_count_mem #(
	parameter int ADDR_W = 6,
	parameter int CNT_W  = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [CNT_W-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [CNT_W-1:0]  wr_data
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [CNT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [CNT_W-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

### src/bcib_bucket_mem.sv
// Bucket storage: one entry per (block, slot), holding constraint and position.
// Synchronous single write port, single read port, registered read data.
module bcib_bucket_mem #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 18
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/block_constraint_index_build.sv
// Block constraint index builder: an insert appends (constraint, position) to the
// bucket of its block and bumps the block's count; a lookup returns the count and
// the entry at a given rank. Every request gives one result word. Throughput is one
// request per cycle while the output is not stalled, and the result word passes from
// the stage 1 register into the output register: the count and bucket memories are
// read when a word is accepted and written back when it leaves stage 1, and a write
// record forwards the newest count and entry to the following request. Counters start
// at zero through per-block valid bits; there is no clearing pass. Depends on bcib_pkg,
// bcib_count_mem and bcib_bucket_mem.
module block_constraint_index_build
	import bcib_pkg::*;
#(
	parameter int NUM_BLOCKS   = NUM_BLOCKS_DEF,
	parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // constraint_id[11:0], position[17:12], block_id[23:18], rank[31:24]
	input  logic             s_tuser,  // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata   // status[1:0], bucket_count[10:2], found_constraint[22:11], found_position[28:23], zero
);

	// only block numbers reachable through the block field get storage
	localparam int NB_EFF = (NUM_BLOCKS < 2 ** BLK_W) ? NUM_BLOCKS : 2 ** BLK_W;
	localparam int BW     = (NB_EFF > 1) ? $clog2(NB_EFF) : 1;
	localparam int IW     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int CW     = $clog2(BUCKET_DEPTH + 1);
	localparam int AW     = BW + IW;
	localparam int DW     = CID_W + POS_W;

	logic [CFG_W-1:0] blocks_in_use_q;

	// stage 1 request
	logic              vld_s1;
	req_t              req_s1;
	logic [CID_W-1:0]  cid_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [BLK_W-1:0]  blk_s1;
	logic [RANK_W-1:0] rank_s1;

	// last write-back, for forwarding
	logic              rec_vld_q;
	logic [BW-1:0]     rec_blk_q;
	logic [CW-1:0]     rec_cnt_q;
	logic [IW-1:0]     rec_idx_q;
	logic [DW-1:0]     rec_data_q;

	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;

	logic              accept;
	logic              adv_s1;
	logic [CW-1:0]     cnt_rd;
	logic [DW-1:0]     bkt_rd;
	logic [CW-1:0]     cnt;
	logic [CW-1:0]     cnt_inc;
	logic [DW-1:0]     entry;
	logic              fwd_cnt;
	logic              blk_ok;
	logic              ins_ok;
	status_t           status;
	logic [COUNT_W-1:0] count_out;
	logic [CID_W-1:0]  fc;
	logic [POS_W-1:0]  fp;

	assign adv_s1   = vld_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !vld_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= BLOCKS_IN_USE_RST;
		end else if (cfg_we) begin
			blocks_in_use_q <= cfg_wdata;
		end
	end

	bcib_count_mem #(
		.ADDR_W (BW),
		.CNT_W  (CW)
	) u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (BW'(s_tdata[23:18])),
		.rd_data (cnt_rd),
		.wr_en   (ins_ok),
		.wr_addr (blk_s1[BW-1:0]),
		.wr_data (cnt_inc)
	);

	bcib_bucket_mem #(
		.ADDR_W (AW),
		.DATA_W (DW)
	) u_bucket_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr ({BW'(s_tdata[23:18]), IW'(s_tdata[31:24])}),
		.rd_data (bkt_rd),
		.wr_en   (ins_ok),
		.wr_addr ({blk_s1[BW-1:0], IW'(cnt)}),
		.wr_data ({cid_s1, pos_s1})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_t'(s_tuser);
			cid_s1  <= s_tdata[11:0];
			pos_s1  <= s_tdata[17:12];
			blk_s1  <= s_tdata[23:18];
			rank_s1 <= s_tdata[31:24];
		end
	end

	always_comb begin
		blk_ok  = ({1'b0, blk_s1} < blocks_in_use_q) && (32'(blk_s1) < NUM_BLOCKS);
		// the record holds the previous write-back, which may have landed in the cycle this read was issued
		fwd_cnt = rec_vld_q && (rec_blk_q == blk_s1[BW-1:0]);
		cnt     = fwd_cnt ? rec_cnt_q : cnt_rd;
		cnt_inc = cnt + CW'(1);
		entry   = (fwd_cnt && (rec_idx_q == IW'(rank_s1))) ? rec_data_q : bkt_rd;
		ins_ok  = adv_s1 && (req_s1 == REQ_INSERT) && blk_ok && (32'(cnt) < BUCKET_DEPTH);
	end

	always_comb begin
		status    = ST_OK;
		count_out = COUNT_W'(cnt);
		fc        = '0;
		fp        = '0;
		priority if (!blk_ok) begin
			status    = ST_RANGE;
			count_out = '0;
		end else if (req_s1 == REQ_INSERT) begin
			if (32'(cnt) >= BUCKET_DEPTH) begin
				status = ST_FULL;
			end else begin
				count_out = COUNT_W'(cnt_inc);
			end
		end else begin
			if ((32'(rank_s1) >= 32'(cnt)) || (32'(rank_s1) >= BUCKET_DEPTH)) begin
				status = ST_RANK;
			end else begin
				fc = entry[DW-1:POS_W];
				fp = entry[POS_W-1:0];
			end
		end
	end

	// keep the record while stage 1 holds; clear it when a word passes without a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_q <= 1'b0;
		end else if (adv_s1) begin
			rec_vld_q <= ins_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_ok) begin
			rec_blk_q  <= blk_s1[BW-1:0];
			rec_cnt_q  <= cnt_inc;
			rec_idx_q  <= IW'(cnt);
			rec_data_q <= {cid_s1, pos_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tdata_q <= {3'b000, fp, fc, count_out, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### verif/block_constraint_index_build_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for block_constraint_index_build: directed table, fill-to-full pass
// and random phases, each word scored against a typed table answer or an in-bench bucket
// index predictor. Depends on bcib_pkg and the block RTL only.
module block_constraint_index_build_tb;
	import bcib_pkg::*;

	localparam int STALL_LIMIT = 5000;

	typedef struct {
		status_t          st;
		logic [COUNT_W-1:0] cnt;
		logic [CID_W-1:0]   fc;
		logic [POS_W-1:0]   fp;
	} bucket_answer_t;

	typedef struct {
		bit               is_cfg;
		logic [CFG_W-1:0] cfg_val;
		req_t             rq;
		logic [CID_W-1:0] cid;
		logic [POS_W-1:0] pos;
		logic [BLK_W-1:0] blk;
		logic [RANK_W-1:0] rnk;
		bit               typed;
		bucket_answer_t   ans;
	} script_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;

	block_constraint_index_build uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// predictor state
	logic [COUNT_W-1:0] blk_fill [NUM_BLOCKS_DEF];
	logic [CID_W-1:0]   slot_cid [NUM_BLOCKS_DEF][BUCKET_DEPTH_DEF];
	logic [POS_W-1:0]   slot_pos [NUM_BLOCKS_DEF][BUCKET_DEPTH_DEF];
	logic [CFG_W-1:0]   active_blocks;

	bucket_answer_t expected_answers [$];
	bucket_answer_t want;
	script_row_t    script [$];

	int errors;
	int idle_cycles;
	int burst_left;
	int n_insert, n_lookup, n_settings;
	int status_hits [4];
	int stall_mode, stall_left;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bucket_answer_t apply_index_request(req_t rq, logic [CID_W-1:0] cid,
			logic [POS_W-1:0] pos, logic [BLK_W-1:0] blk, logic [RANK_W-1:0] rnk);
		bucket_answer_t a;
		a.st  = ST_OK;
		a.cnt = '0;
		a.fc  = '0;
		a.fp  = '0;
		if (int'(blk) >= int'(active_blocks)) begin
			a.st = ST_RANGE;
		end else if (rq == REQ_INSERT) begin
			a.cnt = blk_fill[blk];
			if (int'(blk_fill[blk]) >= BUCKET_DEPTH_DEF) begin
				a.st = ST_FULL;
			end else begin
				slot_cid[blk][blk_fill[blk][7:0]] = cid;
				slot_pos[blk][blk_fill[blk][7:0]] = pos;
				blk_fill[blk] = blk_fill[blk] + 1'b1;
				a.cnt = blk_fill[blk];
			end
		end else begin
			a.cnt = blk_fill[blk];
			if (int'(rnk) >= int'(blk_fill[blk])) begin
				a.st = ST_RANK;
			end else begin
				a.fc = slot_cid[blk][rnk];
				a.fp = slot_pos[blk][rnk];
			end
		end
		return a;
	endfunction

	function automatic script_row_t req_row(req_t rq, int cid, int pos, int blk, int rnk,
			bit typed, status_t st, int cnt, int fc, int fp);
		script_row_t r;
		r.is_cfg  = 1'b0;
		r.cfg_val = '0;
		r.rq      = rq;
		r.cid     = cid[CID_W-1:0];
		r.pos     = pos[POS_W-1:0];
		r.blk     = blk[BLK_W-1:0];
		r.rnk     = rnk[RANK_W-1:0];
		r.typed   = typed;
		r.ans.st  = st;
		r.ans.cnt = cnt[COUNT_W-1:0];
		r.ans.fc  = fc[CID_W-1:0];
		r.ans.fp  = fp[POS_W-1:0];
		return r;
	endfunction

	function automatic script_row_t cfg_row(int v);
		script_row_t r;
		r = req_row(REQ_INSERT, 0, 0, 0, 0, 1'b0, ST_OK, 0, 0, 0);
		r.is_cfg  = 1'b1;
		r.cfg_val = v[CFG_W-1:0];
		return r;
	endfunction

	// Called at a rising edge; leaves s_tvalid high with the accepted word still on the bus,
	// so the caller must present the next word or drop valid in the same time step.
	task automatic push_request(req_t rq, logic [CID_W-1:0] cid, logic [POS_W-1:0] pos,
			logic [BLK_W-1:0] blk, logic [RANK_W-1:0] rnk, bit typed, bucket_answer_t typed_ans);
		int gap;
		bucket_answer_t a;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rq;
		s_tdata  <= {rnk, blk, pos, cid};
		forever begin
			@(negedge clk);
			if (s_tready) break;
			@(posedge clk);
		end
		a = apply_index_request(rq, cid, pos, blk, rnk);
		expected_answers.push_back(typed ? typed_ans : a);
		status_hits[a.st]++;
		if (rq == REQ_INSERT) n_insert++;
		else n_lookup++;
		@(posedge clk);
	endtask

	// Hold off the sender until every pending word has come back, then write the register.
	task automatic set_active_blocks(logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_blocks = v;
		n_settings++;
	endtask

	task automatic random_request();
		req_t rq;
		logic [BLK_W-1:0] blk;
		logic [RANK_W-1:0] rnk;
		int lim;
		bucket_answer_t none;
		none.st = ST_OK;
		none.cnt = '0;
		none.fc = '0;
		none.fp = '0;
		lim = (active_blocks > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(active_blocks);
		rq = ($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_LOOKUP;
		if (lim > 0 && $urandom_range(0, 99) < 85) blk = BLK_W'($urandom_range(0, lim - 1));
		else blk = BLK_W'($urandom);
		rnk = RANK_W'($urandom);
		// mostly aim lookups at stored ranks
		if (rq == REQ_LOOKUP && blk_fill[blk] != 0 && $urandom_range(0, 99) < 85)
			rnk = RANK_W'($urandom_range(0, int'(blk_fill[blk]) - 1));
		push_request(rq, CID_W'($urandom), POS_W'($urandom), blk, rnk, 1'b0, none);
	endtask

	// receiver: pick a new stall style whenever the stall counter runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = 64;
		end
		stall_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_left[2:0] != 3'd0);
		endcase
	end

	// score output words; values are stable at the falling edge before the accepting edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected output word %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_answers.pop_front();
				if (m_tdata[1:0] != want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[10:2] != want.cnt) begin
					$display("%0t: bucket_count expected %0d actual %0d", $time, want.cnt,
						m_tdata[10:2]);
					errors++;
				end
				if (m_tdata[22:11] != want.fc) begin
					$display("%0t: found_constraint expected %0d actual %0d", $time, want.fc,
						m_tdata[22:11]);
					errors++;
				end
				if (m_tdata[28:23] != want.fp) begin
					$display("%0t: found_position expected %0d actual %0d", $time, want.fp,
						m_tdata[28:23]);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("block_constraint_index_build_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int phase_cfg [7];
		int phase_len [7];
		int v;
		bucket_answer_t none;
		script_row_t r;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		m_tready <= 1'b0;
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		n_insert = 0;
		n_lookup = 0;
		n_settings = 0;
		stall_mode = 0;
		stall_left = 0;
		for (int i = 0; i < 4; i++) status_hits[i] = 0;
		for (int b = 0; b < NUM_BLOCKS_DEF; b++) blk_fill[b] = '0;
		active_blocks = BLOCKS_IN_USE_RST;
		none.st = ST_OK;
		none.cnt = '0;
		none.fc = '0;
		none.fp = '0;

		script.push_back(req_row(REQ_LOOKUP, 0, 0, 0, 0, 1, ST_RANK, 0, 0, 0));
		script.push_back(req_row(REQ_INSERT, 4095, 63, 0, 0, 1, ST_OK, 1, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 0, 0, 1, ST_OK, 1, 4095, 63));
		script.push_back(req_row(REQ_INSERT, 0, 0, 63, 0, 1, ST_OK, 1, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 63, 0, 1, ST_OK, 1, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 63, 255, 1, ST_RANK, 1, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 63, 1, 1, ST_RANK, 1, 0, 0));
		script.push_back(req_row(REQ_INSERT, 'hAAA, 'h2A, 'h15, 0, 0, ST_OK, 0, 0, 0));
		script.push_back(req_row(REQ_INSERT, 'h555, 'h15, 'h2A, 'hAA, 0, ST_OK, 0, 0, 0));
		script.push_back(req_row(REQ_INSERT, 'h123, 5, 0, 0, 0, ST_OK, 0, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 0, 1, 0, ST_OK, 0, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 'hFFF, 'h3F, 'h2A, 0, 0, ST_OK, 0, 0, 0));
		script.push_back(req_row(REQ_INSERT, 'h800, 'h20, 'h15, 'hFF, 0, ST_OK, 0, 0, 0));
		script.push_back(cfg_row(1));
		script.push_back(req_row(REQ_INSERT, 9, 9, 1, 0, 1, ST_RANGE, 0, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 63, 0, 1, ST_RANGE, 0, 0, 0));
		script.push_back(req_row(REQ_INSERT, 7, 9, 0, 0, 0, ST_OK, 0, 0, 0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 0, 2, 0, ST_OK, 0, 0, 0));
		script.push_back(cfg_row(0));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 0, 0, 1, ST_RANGE, 0, 0, 0));
		script.push_back(req_row(REQ_INSERT, 1, 1, 0, 0, 1, ST_RANGE, 0, 0, 0));
		script.push_back(cfg_row(127));
		script.push_back(req_row(REQ_LOOKUP, 0, 0, 63, 0, 0, ST_OK, 0, 0, 0));
		script.push_back(req_row(REQ_INSERT, 'hFFF, 'h3F, 63, 0, 0, ST_OK, 0, 0, 0));
		script.push_back(cfg_row(64));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			r = script[i];
			if (r.is_cfg) set_active_blocks(r.cfg_val);
			else push_request(r.rq, r.cid, r.pos, r.blk, r.rnk, r.typed, r.ans);
		end

		// fill block 62 to the brim, push past it, then read both ends
		for (int i = 0; i < BUCKET_DEPTH_DEF + 3; i++)
			push_request(REQ_INSERT, CID_W'($urandom), POS_W'($urandom), BLK_W'(62),
				RANK_W'($urandom), 1'b0, none);
		push_request(REQ_LOOKUP, '0, '0, BLK_W'(62), RANK_W'(255), 1'b0, none);
		push_request(REQ_LOOKUP, '0, '0, BLK_W'(62), '0, 1'b0, none);
		for (int i = 0; i < 4; i++)
			push_request(REQ_LOOKUP, CID_W'($urandom), POS_W'($urandom), BLK_W'(62),
				RANK_W'($urandom), 1'b0, none);

		phase_cfg = '{64, 1, 0, 127, 33, -1, 64};
		phase_len = '{350, 120, 40, 250, 250, 250, 200};
		for (int p = 0; p < 7; p++) begin
			v = (phase_cfg[p] < 0) ? $urandom_range(2, 63) : phase_cfg[p];
			set_active_blocks(v[CFG_W-1:0]);
			for (int i = 0; i < phase_len[p]; i++) random_request();
		end

		s_tvalid <= 1'b0;
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d inserts and %0d lookups over %0d register writes",
			n_insert, n_lookup, n_settings);
		$display("status mix ok/full/rank/range: %0d/%0d/%0d/%0d",
			status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_RANK],
			status_hits[ST_RANGE]);
		if (errors == 0) begin
			$display("block_constraint_index_build_tb: PASS");
		end else begin
			$display("block_constraint_index_build_tb: FAIL");
		end
		$finish;
	end

endmodule
